@@ rtl/tlrd_pkg.sv @@
package tlrd_pkg;

    localparam int unsigned MIN_PACKET_BYTES = 8;

    localparam int unsigned LEN_W = 24;

    // result kinds
    localparam logic [2:0] KIND_LABEL     = 3'd0;
    localparam logic [2:0] KIND_ENTITY    = 3'd1;
    localparam logic [2:0] KIND_CLASS     = 3'd2;
    localparam logic [2:0] KIND_RELATION  = 3'd3;
    localparam logic [2:0] KIND_EVENT     = 3'd4;
    localparam logic [2:0] KIND_NAME_CHAR = 3'd5;
    localparam logic [2:0] KIND_ERROR     = 3'd6;

    // error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN_ID = 2'd1;
    localparam logic [1:0] ERR_TRUNCATED  = 2'd2;

    // declaration ids
    localparam logic [31:0] DECL_LABEL    = 32'd0;
    localparam logic [31:0] DECL_ENTITY   = 32'd1;
    localparam logic [31:0] DECL_CLASS    = 32'd2;
    localparam logic [31:0] DECL_RELATION = 32'd3;
    localparam logic [31:0] DECL_EVENT    = 32'd4;

    // configuration register indexes
    localparam logic REG_THREAD_ID_WIDE = 1'b0;

    typedef enum logic [13:0] {
        PH_IDLE      = 14'h0001,
        PH_DECL      = 14'h0002,
        PH_LBL_GUID  = 14'h0004,
        PH_LBL_LEN   = 14'h0008,
        PH_LBL_NAME  = 14'h0010,
        PH_ENT_GUID  = 14'h0020,
        PH_CLS_GUID  = 14'h0040,
        PH_REL_TYPE  = 14'h0080,
        PH_REL_GUID  = 14'h0100,
        PH_REL_HEAD  = 14'h0200,
        PH_REL_TAIL  = 14'h0400,
        PH_EV_TIME   = 14'h0800,
        PH_EV_THREAD = 14'h1000,
        PH_EV_GUID   = 14'h2000
    } phase_t;

    typedef struct packed {
        logic [2:0]  record_kind;
        logic [63:0] guid;
        logic [63:0] head_guid;
        logic [63:0] tail_guid;
        logic [31:0] relation_type;
        logic [63:0] time_stamp;
        logic [63:0] thread_id;
        logic [31:0] name_length;
        logic [7:0]  name_char;
        logic        name_last;
        logic [1:0]  error_code;
    } rec_t;

endpackage

@@ rtl/tlrd_parser.sv @@
module tlrd_parser
    import tlrd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       data_byte,
    input  logic             first_of_packet,
    input  logic [LEN_W-1:0] packet_bytes,
    input  logic             thread_id_wide,
    output logic             res_valid,
    output rec_t             res
);

    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   left_reg, left_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic [63:0]        shift_reg, shift_next;
    logic [63:0]        guid_reg, guid_next;
    logic [63:0]        head_time_reg, head_time_next;
    logic [63:0]        thread_tail_reg, thread_tail_next;
    logic [31:0]        word_reg, word_next;
    logic [31:0]        nbd_reg, nbd_next;
    logic               discard_reg, discard_next;

    logic               go;
    logic [63:0]        fval;
    logic [31:0]        chars;
    logic [32:0]        name_total;

    function automatic logic [3:0] field_need(phase_t ph, logic wide);
        case (ph)
            PH_DECL, PH_LBL_LEN, PH_REL_TYPE: field_need = 4'd4;
            PH_EV_THREAD:                     field_need = wide ? 4'd8 : 4'd4;
            default:                          field_need = 4'd8;
        endcase
    endfunction

    function automatic logic mid_record(phase_t ph, logic [3:0] cnt);
        mid_record = (ph != PH_IDLE) && !(ph == PH_DECL && cnt == 4'd0);
    endfunction

    function automatic rec_t error_rec(logic [1:0] code);
        rec_t r;
        r = '0;
        r.record_kind = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    assign chars = word_reg - 32'd1;
    assign name_total = ({1'b0, word_reg} + 33'd3) & ~33'd3;

    always_comb
    begin
        phase_next       = phase_reg;
        left_next        = left_reg;
        cnt_next         = cnt_reg;
        shift_next       = shift_reg;
        guid_next        = guid_reg;
        head_time_next   = head_time_reg;
        thread_tail_next = thread_tail_reg;
        word_next        = word_reg;
        nbd_next         = nbd_reg;
        discard_next     = discard_reg;
        res_valid        = 1'b0;
        res              = '0;
        fval             = '0;
        go               = 1'b1;

        if (first_of_packet)
        begin
            // previous packet stopped inside a record
            if (!discard_reg && mid_record(phase_reg, cnt_reg))
            begin
                res_valid = 1'b1;
                res = error_rec(ERR_TRUNCATED);
            end
            cnt_next   = '0;
            shift_next = '0;
            nbd_next   = '0;
            if (packet_bytes < LEN_W'(MIN_PACKET_BYTES))
            begin
                discard_next = 1'b1;
                phase_next   = PH_IDLE;
                left_next    = '0;
                go           = 1'b0;
            end
            else
            begin
                discard_next = 1'b0;
                left_next    = packet_bytes;
                phase_next   = PH_DECL;
            end
        end
        else if (discard_reg || phase_reg == PH_IDLE || left_reg == '0)
        begin
            go = 1'b0;
        end

        if (go)
        begin
            left_next = left_next - LEN_W'(1);

            if (phase_next == PH_LBL_NAME)
            begin
                if (nbd_reg < chars)
                begin
                    res_valid = 1'b1;
                    res.record_kind = KIND_NAME_CHAR;
                    res.name_char = data_byte;
                    res.name_last = (nbd_reg == chars - 32'd1);
                end
                nbd_next = nbd_reg + 32'd1;
                if ({1'b0, nbd_reg} + 33'd1 >= name_total)
                begin
                    phase_next = PH_DECL;
                    nbd_next   = '0;
                end
            end
            else
            begin
                shift_next = shift_next | ({56'd0, data_byte} << {cnt_next[2:0], 3'b000});
                cnt_next   = cnt_next + 4'd1;
                if (cnt_next >= field_need(phase_next, thread_id_wide))
                begin
                    fval       = shift_next;
                    shift_next = '0;
                    cnt_next   = '0;
                    case (phase_next)
                        PH_DECL:
                        begin
                            case (fval[31:0])
                                DECL_LABEL:    phase_next = PH_LBL_GUID;
                                DECL_ENTITY:   phase_next = PH_ENT_GUID;
                                DECL_CLASS:    phase_next = PH_CLS_GUID;
                                DECL_RELATION: phase_next = PH_REL_TYPE;
                                DECL_EVENT:    phase_next = PH_EV_TIME;
                                default:
                                begin
                                    discard_next = 1'b1;
                                    phase_next   = PH_IDLE;
                                    left_next    = '0;
                                    res_valid    = 1'b1;
                                    res          = error_rec(ERR_UNKNOWN_ID);
                                end
                            endcase
                        end
                        PH_LBL_GUID:
                        begin
                            guid_next  = fval;
                            phase_next = PH_LBL_LEN;
                        end
                        PH_LBL_LEN:
                        begin
                            word_next = fval[31:0];
                            nbd_next  = '0;
                            res_valid = 1'b1;
                            res.record_kind = KIND_LABEL;
                            res.guid        = guid_reg;
                            res.name_length = fval[31:0];
                            phase_next = (fval[31:0] == '0) ? PH_DECL : PH_LBL_NAME;
                        end
                        PH_ENT_GUID, PH_CLS_GUID:
                        begin
                            res_valid = 1'b1;
                            res.record_kind = (phase_next == PH_ENT_GUID) ? KIND_ENTITY
                                                                          : KIND_CLASS;
                            res.guid   = fval;
                            phase_next = PH_DECL;
                        end
                        PH_REL_TYPE:
                        begin
                            word_next  = fval[31:0];
                            phase_next = PH_REL_GUID;
                        end
                        PH_REL_GUID:
                        begin
                            guid_next  = fval;
                            phase_next = PH_REL_HEAD;
                        end
                        PH_REL_HEAD:
                        begin
                            head_time_next = fval;
                            phase_next     = PH_REL_TAIL;
                        end
                        PH_REL_TAIL:
                        begin
                            thread_tail_next = fval;
                            res_valid = 1'b1;
                            res.record_kind   = KIND_RELATION;
                            res.guid          = guid_reg;
                            res.head_guid     = head_time_reg;
                            res.tail_guid     = fval;
                            res.relation_type = word_reg;
                            phase_next = PH_DECL;
                        end
                        PH_EV_TIME:
                        begin
                            head_time_next = fval;
                            phase_next     = PH_EV_THREAD;
                        end
                        PH_EV_THREAD:
                        begin
                            thread_tail_next = fval;
                            phase_next       = PH_EV_GUID;
                        end
                        PH_EV_GUID:
                        begin
                            guid_next = fval;
                            res_valid = 1'b1;
                            res.record_kind = KIND_EVENT;
                            res.guid        = fval;
                            res.time_stamp  = head_time_reg;
                            res.thread_id   = thread_tail_reg;
                            phase_next = PH_DECL;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end

            // last byte of the packet: a cut record replaces any other result
            if (!discard_next && left_next == '0 && phase_next != PH_IDLE)
            begin
                if (mid_record(phase_next, cnt_next))
                begin
                    res_valid = 1'b1;
                    res = error_rec(ERR_TRUNCATED);
                end
                phase_next = PH_IDLE;
                cnt_next   = '0;
                shift_next = '0;
                nbd_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            left_reg        <= '0;
            cnt_reg         <= '0;
            shift_reg       <= '0;
            guid_reg        <= '0;
            head_time_reg   <= '0;
            thread_tail_reg <= '0;
            word_reg        <= '0;
            nbd_reg         <= '0;
            discard_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            left_reg        <= left_next;
            cnt_reg         <= cnt_next;
            shift_reg       <= shift_next;
            guid_reg        <= guid_next;
            head_time_reg   <= head_time_next;
            thread_tail_reg <= thread_tail_next;
            word_reg        <= word_next;
            nbd_reg         <= nbd_next;
            discard_reg     <= discard_next;
        end
    end

endmodule

@@ rtl/timeline_record_deframer_unit.sv @@
// Timeline record deframer: takes one packet byte per item and returns at most one
// result per byte (a finished record, a label name character or an error). A byte is
// accepted in every cycle while the result register is empty or being taken; its
// result, if any, is presented on the next cycle, so the block runs at one byte per
// clock, stalling only when out_ready holds a result back. Packets shorter than
// MIN_PACKET_BYTES are dropped. thread_id_wide (address 0) picks a 4- or 8-byte event
// thread id and should be written only while no packet is open.
module timeline_record_deframer_unit
    import tlrd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       data_byte,
    input  logic             first_of_packet,
    input  logic [LEN_W-1:0] packet_bytes,

    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       record_kind,
    output logic [63:0]      guid,
    output logic [63:0]      head_guid,
    output logic [63:0]      tail_guid,
    output logic [31:0]      relation_type,
    output logic [63:0]      time_stamp,
    output logic [63:0]      thread_id,
    output logic [31:0]      name_length,
    output logic [7:0]       name_char,
    output logic             name_last,
    output logic [1:0]       error_code,

    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic  step;
    logic  res_valid;
    rec_t  res;
    rec_t  rec_reg;
    logic  out_valid_reg;
    logic  wide_reg;
    logic  reg_hit;

    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    tlrd_parser u_parser (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .data_byte       (data_byte),
        .first_of_packet (first_of_packet),
        .packet_bytes    (packet_bytes),
        .thread_id_wide  (wide_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            rec_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign record_kind   = rec_reg.record_kind;
    assign guid          = rec_reg.guid;
    assign head_guid     = rec_reg.head_guid;
    assign tail_guid     = rec_reg.tail_guid;
    assign relation_type = rec_reg.relation_type;
    assign time_stamp    = rec_reg.time_stamp;
    assign thread_id     = rec_reg.thread_id;
    assign name_length   = rec_reg.name_length;
    assign name_char     = rec_reg.name_char;
    assign name_last     = rec_reg.name_last;
    assign error_code    = rec_reg.error_code;

    // register file: one word, byte address 4*index
    assign reg_hit = (paddr[2] == REG_THREAD_ID_WIDE) && (paddr[1:0] == 2'b00);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {31'd0, wide_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            wide_reg <= pwdata[0];
        end
    end

    a_err_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_kind == KIND_ERROR |-> error_code != ERR_NONE)
        else $error("error result without error code");

    a_code_only_on_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && record_kind != KIND_ERROR |-> error_code == ERR_NONE)
        else $error("error code on a non-error result");

    a_last_only_on_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && name_last |-> record_kind == KIND_NAME_CHAR)
        else $error("name_last outside a name character");

    a_short_packet: assert property (@(posedge clk) disable iff (!rst_n)
        step && first_of_packet && packet_bytes < LEN_W'(MIN_PACKET_BYTES)
        |=> !out_valid || record_kind == KIND_ERROR)
        else $error("short packet produced a record");

endmodule

@@ bench/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tlrd_pkg::*;

    localparam logic [2:0] WIDE_ADDR = 3'(4 * REG_THREAD_ID_WIDE);

    typedef struct packed {
        logic [7:0]  b;
        logic        first;
        logic [23:0] len;
    } byte_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  data_byte = '0;
    logic        first_of_packet = 1'b0;
    logic [23:0] packet_bytes = '0;
    logic        out_ready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;

    logic        in_ready;
    logic        out_valid;
    logic [2:0]  record_kind;
    logic [63:0] guid;
    logic [63:0] head_guid;
    logic [63:0] tail_guid;
    logic [31:0] relation_type;
    logic [63:0] time_stamp;
    logic [63:0] thread_id;
    logic [31:0] name_length;
    logic [7:0]  name_char;
    logic        name_last;
    logic [1:0]  error_code;
    logic [31:0] prdata;
    logic        pready;

    timeline_record_deframer_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
        .first_of_packet(first_of_packet), .packet_bytes(packet_bytes),
        .out_valid(out_valid), .out_ready(out_ready), .record_kind(record_kind),
        .guid(guid), .head_guid(head_guid), .tail_guid(tail_guid),
        .relation_type(relation_type), .time_stamp(time_stamp), .thread_id(thread_id),
        .name_length(name_length), .name_char(name_char), .name_last(name_last),
        .error_code(error_code),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    byte_item_t  byte_q[$];
    rec_t        pending_recs[$];
    logic [7:0]  pkt[$];
    int unsigned bytes_queued = 0;
    int unsigned bytes_taken = 0;
    int unsigned recs_seen = 0;
    int unsigned mismatches = 0;

    // deframer state as predicted
    phase_t      ph = PH_IDLE;
    logic [23:0] left_cnt = '0;
    logic [3:0]  fcnt = '0;
    logic [63:0] fshift = '0;
    logic [63:0] h_guid = '0, h_head = '0, h_tail = '0;
    logic [31:0] h_word = '0, name_done = '0;
    logic        discard = 1'b0;
    logic        wide_cfg = 1'b0;

    function automatic rec_t error_rec(input logic [1:0] code);
        rec_t r;
        r = '0;
        r.record_kind = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    function automatic logic in_record();
        return ph != PH_IDLE && !(ph == PH_DECL && fcnt == 0);
    endfunction

    function automatic int field_len();
        case (ph)
            PH_DECL, PH_LBL_LEN, PH_REL_TYPE: return 4;
            PH_EV_THREAD: return wide_cfg ? 8 : 4;
            default: return 8;
        endcase
    endfunction

    function automatic logic finish_field(input logic [63:0] v, output rec_t r);
        r = '0;
        case (ph)
            PH_DECL: begin
                case (v[31:0])
                    DECL_LABEL:    ph = PH_LBL_GUID;
                    DECL_ENTITY:   ph = PH_ENT_GUID;
                    DECL_CLASS:    ph = PH_CLS_GUID;
                    DECL_RELATION: ph = PH_REL_TYPE;
                    DECL_EVENT:    ph = PH_EV_TIME;
                    default:
                    begin
                        discard = 1'b1;
                        ph = PH_IDLE;
                        left_cnt = '0;
                        r = error_rec(ERR_UNKNOWN_ID);
                        return 1'b1;
                    end
                endcase
            end
            PH_LBL_GUID:
            begin
                h_guid = v;
                ph = PH_LBL_LEN;
            end
            PH_LBL_LEN:
            begin
                h_word = v[31:0];
                name_done = '0;
                r.record_kind = KIND_LABEL;
                r.guid = h_guid;
                r.name_length = h_word;
                if (h_word == 0)
                    ph = PH_DECL;
                else
                    ph = PH_LBL_NAME;
                return 1'b1;
            end
            PH_ENT_GUID, PH_CLS_GUID:
            begin
                r.record_kind = (ph == PH_ENT_GUID) ? KIND_ENTITY : KIND_CLASS;
                r.guid = v;
                ph = PH_DECL;
                return 1'b1;
            end
            PH_REL_TYPE:
            begin
                h_word = v[31:0];
                ph = PH_REL_GUID;
            end
            PH_REL_GUID:
            begin
                h_guid = v;
                ph = PH_REL_HEAD;
            end
            PH_REL_HEAD:
            begin
                h_head = v;
                ph = PH_REL_TAIL;
            end
            PH_REL_TAIL:
            begin
                h_tail = v;
                r.record_kind = KIND_RELATION;
                r.guid = h_guid;
                r.head_guid = h_head;
                r.tail_guid = h_tail;
                r.relation_type = h_word;
                ph = PH_DECL;
                return 1'b1;
            end
            PH_EV_TIME:
            begin
                h_head = v;
                ph = PH_EV_THREAD;
            end
            PH_EV_THREAD:
            begin
                h_tail = v;
                ph = PH_EV_GUID;
            end
            PH_EV_GUID:
            begin
                h_guid = v;
                r.record_kind = KIND_EVENT;
                r.guid = h_guid;
                r.time_stamp = h_head;
                r.thread_id = h_tail;
                ph = PH_DECL;
                return 1'b1;
            end
            default: ph = PH_IDLE;
        endcase
        return 1'b0;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic first,
                                         input logic [23:0] len);
        rec_t        r;
        rec_t        fr;
        logic        have;
        logic [31:0] chars;
        logic [31:0] i;
        logic [63:0] v;
        have = 1'b0;
        r = '0;
        if (first) begin
            if (!discard && in_record()) begin
                r = error_rec(ERR_TRUNCATED);
                have = 1'b1;
            end
            fcnt = '0;
            fshift = '0;
            name_done = '0;
            if (len < MIN_PACKET_BYTES) begin
                discard = 1'b1;
                ph = PH_IDLE;
                left_cnt = '0;
                if (have)
                    pending_recs.push_back(r);
                return;
            end
            discard = 1'b0;
            left_cnt = len;
            ph = PH_DECL;
        end
        else if (discard || ph == PH_IDLE || left_cnt == 0) begin
            return;
        end

        left_cnt = left_cnt - 1'b1;

        if (ph == PH_LBL_NAME) begin
            chars = (h_word == 0) ? 32'd0 : h_word - 1;
            i = name_done;
            if (i < chars) begin
                r = '0;
                r.record_kind = KIND_NAME_CHAR;
                r.name_char = b;
                r.name_last = (i == chars - 1);
                have = 1'b1;
            end
            name_done = i + 1;
            // name plus padding is rounded up to whole words
            if (34'(i) + 34'd1 >= ((34'(h_word) + 34'd3) & ~34'd3)) begin
                ph = PH_DECL;
                name_done = '0;
            end
        end
        else begin
            fshift = fshift | (64'(b) << (8 * fcnt[2:0]));
            fcnt = fcnt + 1'b1;
            if (fcnt >= field_len()) begin
                v = fshift;
                fshift = '0;
                fcnt = '0;
                if (finish_field(v, fr)) begin
                    r = fr;
                    have = 1'b1;
                end
            end
        end

        // packet ran out: a half-read record becomes a truncation error
        if (!discard && left_cnt == 0 && ph != PH_IDLE) begin
            if (in_record()) begin
                r = error_rec(ERR_TRUNCATED);
                have = 1'b1;
            end
            ph = PH_IDLE;
            fcnt = '0;
            fshift = '0;
            name_done = '0;
        end
        if (have)
            pending_recs.push_back(r);
    endfunction

    function automatic void check_field(input string fname, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h, got %h", $time, fname, want, got);
            mismatches++;
        end
    endfunction

    // sender: bursts with random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge clk) begin : sender
        byte_item_t it;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                deframe_byte(data_byte, first_of_packet, packet_bytes);
                bytes_taken++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (byte_q.size() != 0) begin
                    it = byte_q.pop_front();
                    data_byte <= it.b;
                    first_of_packet <= it.first;
                    packet_bytes <= it.len;
                    in_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else begin
                        burst_left--;
                    end
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks results and stalls on its own pattern
    int unsigned hold_left = 0;
    int unsigned mode_left = 0;
    int unsigned rx_mode = 0;

    always @(posedge clk) begin : receiver
        rec_t want;
        logic took;
        took = 1'b0;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                took = 1'b1;
                recs_seen++;
                if (pending_recs.size() == 0) begin
                    $display("%0t: unexpected item, kind %0d", $time, record_kind);
                    mismatches++;
                end
                else begin
                    want = pending_recs.pop_front();
                    check_field("record_kind", 64'(want.record_kind), 64'(record_kind));
                    check_field("guid", want.guid, guid);
                    check_field("head_guid", want.head_guid, head_guid);
                    check_field("tail_guid", want.tail_guid, tail_guid);
                    check_field("relation_type", 64'(want.relation_type),
                                64'(relation_type));
                    check_field("time_stamp", want.time_stamp, time_stamp);
                    check_field("thread_id", want.thread_id, thread_id);
                    check_field("name_length", 64'(want.name_length), 64'(name_length));
                    check_field("name_char", 64'(want.name_char), 64'(name_char));
                    check_field("name_last", 64'(want.name_last), 64'(name_last));
                    check_field("error_code", 64'(want.error_code), 64'(error_code));
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (took && (recs_seen == 40 || recs_seen == 160)) begin
                // long hold-off so the block backs up into its input
                hold_left = 300;
                out_ready <= 1'b0;
            end
            else begin
                if (mode_left == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 80);
                end
                else begin
                    mode_left--;
                end
                case (rx_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= !out_ready;
                endcase
            end
        end
    end

    // packet building
    task automatic push_byte(input logic [7:0] b, input logic first, input logic [23:0] len);
        byte_item_t it;
        it.b = b;
        it.first = first;
        it.len = len;
        byte_q.push_back(it);
        bytes_queued++;
    endtask

    task automatic put_word(input logic [63:0] v, input int n);
        for (int k = 0; k < n; k++)
            pkt.push_back(v[8*k +: 8]);
    endtask

    task automatic put_label(input logic [63:0] g, input logic [31:0] nlen);
        logic [33:0] nb;
        put_word(64'(DECL_LABEL), 4);
        put_word(g, 8);
        put_word(64'(nlen), 4);
        nb = (34'(nlen) + 34'd3) & ~34'd3;
        if (nb > 16)
            nb = 16;
        for (int k = 0; k < int'(nb); k++)
            pkt.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic put_guid_rec(input logic [31:0] id, input logic [63:0] g);
        put_word(64'(id), 4);
        put_word(g, 8);
    endtask

    task automatic put_relation(input logic [31:0] rtype, input logic [63:0] g,
                                input logic [63:0] hd, input logic [63:0] tl);
        put_word(64'(DECL_RELATION), 4);
        put_word(64'(rtype), 4);
        put_word(g, 8);
        put_word(hd, 8);
        put_word(tl, 8);
    endtask

    task automatic put_event(input logic [63:0] ts, input logic [63:0] tid,
                             input logic [63:0] g);
        put_word(64'(DECL_EVENT), 4);
        put_word(ts, 8);
        put_word(tid, wide_cfg ? 8 : 4);
        put_word(g, 8);
    endtask

    task automatic send_packet(input logic [23:0] decl_len, input int sent);
        for (int k = 0; k < sent && k < pkt.size(); k++)
            push_byte(pkt[k], k == 0, (k == 0) ? decl_len : 24'($urandom));
        pkt.delete();
    endtask

    task automatic send_noise(input int n);
        for (int k = 0; k < n; k++)
            push_byte(8'($urandom), 1'b0, 24'($urandom));
    endtask

    // a runt packet leaves the block with no packet open
    task automatic close_packet();
        push_byte(8'($urandom), 1'b1, 24'($urandom_range(0, MIN_PACKET_BYTES - 1)));
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_packet();
        int          nrec;
        int          sel;
        int          n;
        logic [31:0] nlen;
        nrec = $urandom_range(1, 4);
        for (int r = 0; r < nrec; r++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) begin
                case ($urandom_range(0, 19))
                    0: nlen = $urandom;
                    1: nlen = 0;
                    default: nlen = $urandom_range(1, 13);
                endcase
                put_label(rand64(), nlen);
            end
            else if (sel < 45)
                put_guid_rec(DECL_ENTITY, rand64());
            else if (sel < 60)
                put_guid_rec(DECL_CLASS, rand64());
            else if (sel < 75)
                put_relation($urandom, rand64(), rand64(), rand64());
            else if (sel < 95)
                put_event(rand64(), rand64(), rand64());
            else begin
                put_word(64'($urandom_range(32'hFFFF_FFFF, 5)), 4);
                put_word(rand64(), 4);
            end
        end
        n = pkt.size();
        case ($urandom_range(0, 19))
            13, 14: send_packet(24'($urandom_range(MIN_PACKET_BYTES, n - 1)), n);
            15, 16: send_packet(24'($urandom_range(n, 24'hFF_FFFF)), n);
            17: send_packet(24'($urandom_range(n, 24'hFF_FFFF)), $urandom_range(1, n - 1));
            18: send_packet(24'($urandom_range(0, MIN_PACKET_BYTES - 1)), n);
            default: send_packet(24'(n), n);
        endcase
        if ($urandom_range(0, 7) == 0)
            send_noise($urandom_range(1, 3));
    endtask

    task automatic drain();
        while (bytes_taken != bytes_queued)
            @(posedge clk);
        while (pending_recs.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_thread_width(input logic w);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= WIDE_ADDR;
        pwdata <= 32'(w);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        wide_cfg = w;
        @(posedge clk);
        psel <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata[0] !== w) begin
            $display("%0t: thread_id_wide readback expected %b, got %b", $time, w, prdata[0]);
            mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        int start;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: every record kind at field extremes
        put_guid_rec(DECL_ENTITY, '1);
        put_guid_rec(DECL_CLASS, '0);
        send_packet(24'(pkt.size()), pkt.size());
        put_label(64'h0123_4567_89AB_CDEF, 32'd5);
        put_label('1, 32'd0);
        put_label('0, 32'd1);
        send_packet(24'(pkt.size()), pkt.size());
        put_relation(32'hFFFF_FFFF, '0, '1, 64'hA5A5_5A5A_0F0F_F0F0);
        put_event('1, 64'hFFFF_FFFF, 64'h8000_0000_0000_0001);
        send_packet(24'(pkt.size()), pkt.size());
        // runt packets and stray bytes are dropped
        put_guid_rec(DECL_ENTITY, rand64());
        send_packet(24'(MIN_PACKET_BYTES - 1), pkt.size());
        send_noise(3);
        push_byte(8'hFF, 1'b1, 24'd0);
        // unknown declaration ids
        put_word(64'hFFFF_FFFF, 4);
        put_guid_rec(DECL_ENTITY, rand64());
        send_packet(24'(pkt.size()), pkt.size());
        put_word(64'd5, 4);
        put_word(rand64(), 8);
        send_packet(24'(pkt.size()), pkt.size());
        // truncated inside a declaration id, and inside a guid
        put_guid_rec(DECL_ENTITY, rand64());
        put_word(64'(DECL_CLASS), 2);
        send_packet(24'd14, pkt.size());
        put_guid_rec(DECL_CLASS, rand64());
        send_packet(24'd10, pkt.size());
        // packet ends on a name character
        put_label(rand64(), 32'd9);
        send_packet(24'd19, pkt.size());
        // restart mid-record, then restart between records
        put_guid_rec(DECL_ENTITY, rand64());
        send_packet(24'hFF_FFFF, 6);
        put_guid_rec(DECL_ENTITY, rand64());
        send_packet(24'h80_0000, pkt.size());
        // name longer than the packet
        put_label(rand64(), 32'hFFFF_FFFF);
        send_packet(24'(pkt.size()), pkt.size());
        close_packet();
        drain();

        set_thread_width(1'b1);
        put_event(64'h0, '1, '1);
        put_event(rand64(), rand64(), rand64());
        send_packet(24'(pkt.size()), pkt.size());
        close_packet();
        drain();

        for (int p = 0; p < 4; p++) begin
            set_thread_width(p[0]);
            start = bytes_queued;
            while (bytes_queued - start < 90)
                random_packet();
            close_packet();
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_recs.size() == 0)
            $display("timeline_record_deframer_unit: match");
        else
            $display("timeline_record_deframer_unit: mismatch");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeline_record_deframer_unit: mismatch");
        $finish;
    end

endmodule
